// ===== hdl/tpc_pkg.sv =====
// Shared constants for the three-point curvature pipeline.
`default_nettype none
package tpc_pkg;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int PORT_BITS       = 32;
    localparam int QUO_BITS        = 32;
    localparam int CURV_SCALE      = 1000;
    localparam int FALLBACK_RADIUS = 999999;
    localparam logic [QUO_BITS-1:0] FALLBACK_CURV =
        QUO_BITS'((64'(CURV_SCALE) << 16) / FALLBACK_RADIUS);
    localparam logic [QUO_BITS-1:0] CURV_MAX = '1;
endpackage
`default_nettype wire

// ===== hdl/three_point_curvature.sv =====
// Three-point curvature: fully pipelined, one transfer per cycle in and out.
// Stages from input transfer to result: 3 setup stages, one square-root stage per
// root bit (COORD_BITS + 1 of them), 2 multiply stages, a saturation stage,
// 32 divide stages, output. Throughput: one item per cycle; the whole pipeline
// holds while a result waits. Reset (aresetn low, synchronous) clears every valid bit.
`default_nettype none
module three_point_curvature
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [PORT_BITS-1:0] s_p0_x,
    input  wire logic signed [PORT_BITS-1:0] s_p0_y,
    input  wire logic                        s_p0_ok,
    input  wire logic signed [PORT_BITS-1:0] s_p1_x,
    input  wire logic signed [PORT_BITS-1:0] s_p1_y,
    input  wire logic                        s_p1_ok,
    input  wire logic signed [PORT_BITS-1:0] s_p2_x,
    input  wire logic signed [PORT_BITS-1:0] s_p2_y,
    input  wire logic                        s_p2_ok,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [QUO_BITS-1:0]              m_curvature,
    output logic                             m_curvature_valid,
    output logic                             m_saturated
);
    localparam int W   = COORD_BITS;
    localparam int DW  = W + 1;                 // difference width
    localparam int PRW = 2 * DW;                // product width
    localparam int CB  = 2 * W + 2;             // |cross|, |dot|, sum of squares
    localparam int RW  = W + 1;                 // square-root width
    localparam int RMB = RW + 2;                // root remainder width
    localparam int PH  = CB / 2;
    localparam int MB  = RW + CB;               // denominator width
    localparam int NB  = CB + 10 + FRAC_BITS + 16;
    localparam int XB  = ((NB > MB + QUO_BITS) ? NB : MB + QUO_BITS) + 1;

    // Whole pipeline advances unless a finished result is held back.
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // Coordinate extraction: low COORD_BITS bits, sign extended.
    logic signed [PORT_BITS-1:0] raw [6];
    logic signed [W-1:0]         crd [6];
    assign raw[0] = s_p0_x;
    assign raw[1] = s_p0_y;
    assign raw[2] = s_p1_x;
    assign raw[3] = s_p1_y;
    assign raw[4] = s_p2_x;
    assign raw[5] = s_p2_y;
    for (genvar g = 0; g < 6; g++) begin : g_crd
        if (W <= PORT_BITS) begin : g_lo
            assign crd[g] = raw[g][W-1:0];
        end else begin : g_ext
            assign crd[g] = {{(W-PORT_BITS){raw[g][PORT_BITS-1]}}, raw[g]};
        end
    end

    // Stage 1: differences p1-p0, p2-p1, p2-p0.
    logic                 v1_reg, ok1_reg;
    logic signed [DW-1:0] dx10_reg, dy10_reg, dx21_reg, dy21_reg, dx20_reg, dy20_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            ok1_reg  <= s_p0_ok && s_p1_ok && s_p2_ok;
            dx10_reg <= DW'(crd[2]) - DW'(crd[0]);
            dy10_reg <= DW'(crd[3]) - DW'(crd[1]);
            dx21_reg <= DW'(crd[4]) - DW'(crd[2]);
            dy21_reg <= DW'(crd[5]) - DW'(crd[3]);
            dx20_reg <= DW'(crd[4]) - DW'(crd[0]);
            dy20_reg <= DW'(crd[5]) - DW'(crd[1]);
        end
    end

    // Stage 2: the six products.
    logic                  v2_reg, ok2_reg;
    logic signed [PRW-1:0] pc0_reg, pc1_reg, pp0_reg, pp1_reg, ps0_reg, ps1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            ok2_reg <= ok1_reg;
            pc0_reg <= dx10_reg * dy21_reg;
            pc1_reg <= dy10_reg * dx21_reg;
            pp0_reg <= dx21_reg * dx20_reg;
            pp1_reg <= dy21_reg * dy20_reg;
            ps0_reg <= dx10_reg * dx10_reg;
            ps1_reg <= dy10_reg * dy10_reg;
        end
    end

    // Stage 3: cross, dot and squared length; feeds the root pipeline at index 0.
    logic signed [PRW:0] cross_s, dot_s;
    logic [PRW:0]        cross_a, dot_a;
    logic [PRW:0]        sq_sum;
    always_comb begin
        cross_s = (PRW+1)'(pc0_reg) - (PRW+1)'(pc1_reg);
        dot_s   = (PRW+1)'(pp0_reg) + (PRW+1)'(pp1_reg);
        cross_a = cross_s[PRW] ? -cross_s : cross_s;
        dot_a   = dot_s[PRW] ? -dot_s : dot_s;
        sq_sum  = (PRW+1)'(ps0_reg) + (PRW+1)'(ps1_reg);
    end

    logic           sq_v_reg    [0:RW];
    logic           sq_ok_reg   [0:RW];
    logic           sq_zero_reg [0:RW];
    logic [CB-1:0]  sq_s_reg    [0:RW];
    logic [CB-1:0]  sq_c_reg    [0:RW];
    logic [CB-1:0]  sq_p_reg    [0:RW];
    logic [RMB-1:0] sq_rem_reg  [0:RW];
    logic [RW-1:0]  sq_root_reg [0:RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= v2_reg;
        end
        if (en) begin
            sq_ok_reg[0]   <= ok2_reg;
            sq_zero_reg[0] <= (cross_a == '0) || (dot_a == '0);
            sq_s_reg[0]    <= sq_sum[CB-1:0];
            sq_c_reg[0]    <= cross_a[CB-1:0];
            sq_p_reg[0]    <= dot_a[CB-1:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // Square root, one root bit per stage, two radicand bits brought down each.
    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        logic [RMB-1:0] rem_sh, trial;
        always_comb begin
            rem_sh = {sq_rem_reg[i][RMB-3:0], sq_s_reg[i][2*(RW-1-i) +: 2]};
            trial  = {sq_root_reg[i], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
            if (en) begin
                sq_ok_reg[i+1]   <= sq_ok_reg[i];
                sq_zero_reg[i+1] <= sq_zero_reg[i];
                sq_s_reg[i+1]    <= sq_s_reg[i];
                sq_c_reg[i+1]    <= sq_c_reg[i];
                sq_p_reg[i+1]    <= sq_p_reg[i];
                if (rem_sh >= trial) begin
                    sq_rem_reg[i+1]  <= rem_sh - trial;
                    sq_root_reg[i+1] <= {sq_root_reg[i][RW-2:0], 1'b1};
                end else begin
                    sq_rem_reg[i+1]  <= rem_sh;
                    sq_root_reg[i+1] <= {sq_root_reg[i][RW-2:0], 1'b0};
                end
            end
        end
    end

    // Multiply stage 1: length times |dot| as two partial products; scale cross.
    logic                 mu1_v_reg, mu1_ok_reg, mu1_zero_reg;
    logic [RW+PH-1:0]     mu1_lo_reg;
    logic [RW+CB-PH-1:0]  mu1_hi_reg;
    logic [NB-1:0]        mu1_n_reg;
    logic [CB+9:0]        c_scaled;
    always_comb begin
        // times 1000 = 1024 - 16 - 8
        c_scaled = ((CB+10)'(sq_c_reg[RW]) << 10) - ((CB+10)'(sq_c_reg[RW]) << 4)
                 - ((CB+10)'(sq_c_reg[RW]) << 3);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu1_v_reg <= 1'b0;
        end else if (en) begin
            mu1_v_reg <= sq_v_reg[RW];
        end
        if (en) begin
            mu1_ok_reg   <= sq_ok_reg[RW];
            mu1_zero_reg <= sq_zero_reg[RW];
            mu1_lo_reg   <= (RW+PH)'(sq_root_reg[RW]) * (RW+PH)'(sq_p_reg[RW][PH-1:0]);
            mu1_hi_reg   <= (RW+CB-PH)'(sq_root_reg[RW]) *
                            (RW+CB-PH)'(sq_p_reg[RW][CB-1:PH]);
            mu1_n_reg    <= NB'(c_scaled) << (FRAC_BITS + 16);
        end
    end

    // Multiply stage 2: combine partial products into the denominator.
    logic          mu2_v_reg, mu2_ok_reg, mu2_zero_reg;
    logic [MB-1:0] mu2_m_reg;
    logic [NB-1:0] mu2_n_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu2_v_reg <= 1'b0;
        end else if (en) begin
            mu2_v_reg <= mu1_v_reg;
        end
        if (en) begin
            mu2_ok_reg   <= mu1_ok_reg;
            mu2_zero_reg <= mu1_zero_reg;
            mu2_m_reg    <= MB'(mu1_lo_reg) + (MB'(mu1_hi_reg) << PH);
            mu2_n_reg    <= mu1_n_reg;
        end
    end

    // Saturation check feeds the divider at index 0.
    logic                dv_v_reg    [0:QUO_BITS];
    logic                dv_ok_reg   [0:QUO_BITS];
    logic                dv_zero_reg [0:QUO_BITS];
    logic                dv_sat_reg  [0:QUO_BITS];
    logic [MB-1:0]       dv_m_reg    [0:QUO_BITS];
    logic [XB-1:0]       dv_r_reg    [0:QUO_BITS];
    logic [QUO_BITS-1:0] dv_q_reg    [0:QUO_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= mu2_v_reg;
        end
        if (en) begin
            dv_ok_reg[0]   <= mu2_ok_reg;
            dv_zero_reg[0] <= mu2_zero_reg;
            dv_sat_reg[0]  <= XB'(mu2_n_reg) >= (XB'(mu2_m_reg) << QUO_BITS);
            dv_m_reg[0]    <= mu2_m_reg;
            dv_r_reg[0]    <= XB'(mu2_n_reg);
            dv_q_reg[0]    <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, top bit first.
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        logic [XB-1:0] shifted;
        assign shifted = XB'(dv_m_reg[k]) << (QUO_BITS - 1 - k);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            if (en) begin
                dv_ok_reg[k+1]   <= dv_ok_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_sat_reg[k+1]  <= dv_sat_reg[k];
                dv_m_reg[k+1]    <= dv_m_reg[k];
                if (dv_r_reg[k] >= shifted) begin
                    dv_r_reg[k+1] <= dv_r_reg[k] - shifted;
                    dv_q_reg[k+1] <= dv_q_reg[k] | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
                end else begin
                    dv_r_reg[k+1] <= dv_r_reg[k];
                    dv_q_reg[k+1] <= dv_q_reg[k];
                end
            end
        end
    end

    // Output register: pick missing, fallback, clamped or quotient result.
    logic                out_v_reg, out_ok_reg, out_sat_reg;
    logic [QUO_BITS-1:0] out_curv_reg;
    logic                out_ok_next, out_sat_next;
    logic [QUO_BITS-1:0] out_curv_next;
    always_comb begin
        out_ok_next   = dv_ok_reg[QUO_BITS];
        out_sat_next  = 1'b0;
        out_curv_next = dv_q_reg[QUO_BITS];
        if (!dv_ok_reg[QUO_BITS]) begin
            out_curv_next = '0;
        end else if (dv_zero_reg[QUO_BITS]) begin
            out_curv_next = FALLBACK_CURV;
        end else if (dv_sat_reg[QUO_BITS]) begin
            out_curv_next = CURV_MAX;
            out_sat_next  = 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_v_reg[QUO_BITS];
        end
        if (en) begin
            out_ok_reg   <= out_ok_next;
            out_sat_reg  <= out_sat_next;
            out_curv_reg <= out_curv_next;
        end
    end

    assign m_valid           = out_v_reg;
    assign m_curvature       = out_curv_reg;
    assign m_curvature_valid = out_ok_reg;
    assign m_saturated       = out_sat_reg;
endmodule
`default_nettype wire

// ===== hdl/tpc_checker.sv =====
// Port-level checks for the three-point curvature block, with its bind.
`default_nettype none
module tpc_checker
    import tpc_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [QUO_BITS-1:0] m_curvature,
    input wire logic                m_curvature_valid,
    input wire logic                m_saturated
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_curvature)
            && $stable(m_curvature_valid) && $stable(m_saturated))
        else $error("result changed while stalled");

    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_curvature_valid && m_curvature == CURV_MAX)
        else $error("clamped result not at maximum");

    a_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_curvature_valid |-> m_curvature == '0 && !m_saturated)
        else $error("missing result not cleared");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind three_point_curvature tpc_checker u_tpc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_curvature       (m_curvature),
    .m_curvature_valid (m_curvature_valid),
    .m_saturated       (m_saturated)
);
`default_nettype wire

// ===== tb/sv/three_point_curvature_checker.sv =====
// Checker for the three-point curvature block: predicts each result and compares it.
module three_point_curvature_checker
    import tpc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [PORT_BITS-1:0] s_p0_x,
    input  logic signed [PORT_BITS-1:0] s_p0_y,
    input  logic                        s_p0_ok,
    input  logic signed [PORT_BITS-1:0] s_p1_x,
    input  logic signed [PORT_BITS-1:0] s_p1_y,
    input  logic                        s_p1_ok,
    input  logic signed [PORT_BITS-1:0] s_p2_x,
    input  logic signed [PORT_BITS-1:0] s_p2_y,
    input  logic                        s_p2_ok,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [QUO_BITS-1:0]         m_curvature,
    input  logic                        m_curvature_valid,
    input  logic                        m_saturated,
    output int                          fail_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [QUO_BITS-1:0] curvature;
        logic                curvature_valid;
        logic                saturated;
    } curv_result_t;

    curv_result_t curv_expected_q[$];

    function automatic logic [255:0] magnitude(input logic signed [255:0] v);
        return v[255] ? -v : v;
    endfunction

    function automatic curv_result_t predict_curvature(
        input logic signed [31:0] x0, input logic signed [31:0] y0, input logic ok0,
        input logic signed [31:0] x1, input logic signed [31:0] y1, input logic ok1,
        input logic signed [31:0] x2, input logic signed [31:0] y2, input logic ok2);
        curv_result_t r;
        logic signed [255:0] ax, ay, bx, by, ex, ey;
        logic [255:0] cross_abs, dot_abs, len_sq, root, cand, num, den, quo;
        r = '0;
        if (!(ok0 && ok1 && ok2)) return r;
        r.curvature_valid = 1'b1;
        ax = 256'(x1) - 256'(x0);  ay = 256'(y1) - 256'(y0);
        bx = 256'(x2) - 256'(x1);  by = 256'(y2) - 256'(y1);
        ex = 256'(x2) - 256'(x0);  ey = 256'(y2) - 256'(y0);
        cross_abs = magnitude(ax * by - ay * bx);
        dot_abs   = magnitude(bx * ex + by * ey);
        len_sq    = ax * ax + ay * ay;
        if (cross_abs == 0 || dot_abs == 0) begin
            r.curvature = FALLBACK_CURV;
            return r;
        end
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (256'd1 << b);
            if (cand * cand <= len_sq) root = cand;
        end
        num = (cross_abs * 256'(CURV_SCALE)) << (FRAC_BITS_DEF + 16);
        den = root * dot_abs;
        quo = num / den;
        if (quo >= (256'd1 << 32)) begin
            r.curvature = CURV_MAX;
            r.saturated = 1'b1;
        end else begin
            r.curvature = quo[31:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        curv_result_t got, want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_curvature, m_curvature_valid, m_saturated};
                if (curv_expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = curv_expected_q.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.curvature != want.curvature)
                            $error("curvature: expected %h, got %h",
                                   want.curvature, got.curvature);
                        if (got.curvature_valid != want.curvature_valid)
                            $error("curvature_valid: expected %b, got %b",
                                   want.curvature_valid, got.curvature_valid);
                        if (got.saturated != want.saturated)
                            $error("saturated: expected %b, got %b",
                                   want.saturated, got.saturated);
                    end
                end
            end
            if (s_valid && s_ready)
                curv_expected_q.push_back(predict_curvature(
                    s_p0_x, s_p0_y, s_p0_ok, s_p1_x, s_p1_y, s_p1_ok,
                    s_p2_x, s_p2_y, s_p2_ok));
        end
        pending_count <= curv_expected_q.size();
    end
endmodule

// ===== tb/sv/three_point_curvature_tb.sv =====
// Top-level testbench for the three-point curvature block: stimulus and verdict.
module three_point_curvature_tb;
    import tpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;   // comfortably past the pipeline depth
    localparam int STALL_LIMIT  = 5000;  // cycles without any transfer
    localparam int RANDOM_ITEMS = 550;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready;
    logic signed [PORT_BITS-1:0] s_p0_x, s_p0_y, s_p1_x, s_p1_y, s_p2_x, s_p2_y;
    logic s_p0_ok, s_p1_ok, s_p2_ok;
    logic m_valid, m_ready;
    logic [QUO_BITS-1:0] m_curvature;
    logic m_curvature_valid, m_saturated;
    int   fail_count, pending_count;
    int   cycle_count;
    int   quiet_cycles;

    three_point_curvature DUT (.*);

    three_point_curvature_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Count cycles and idle stretches; end the run if transfers stop for too long.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall with a chance of about 9 in 100, except for a long no-stall window
    // that overlaps the gap-free stretch on the input side.
    always @(negedge aclk) begin
        if (cycle_count > 200 && cycle_count < 400)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 99) >= 9);
    end

    // Hold one triple on the channel until its transfer completes.
    task automatic drive_triple(
        input logic [31:0] x0, input logic [31:0] y0, input logic ok0,
        input logic [31:0] x1, input logic [31:0] y1, input logic ok1,
        input logic [31:0] x2, input logic [31:0] y2, input logic ok2,
        input bit allow_gap);
        if (allow_gap) begin
            while ($urandom_range(0, 99) < 9) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_p0_x <= x0;  s_p0_y <= y0;  s_p0_ok <= ok0;
        s_p1_x <= x1;  s_p1_y <= y1;  s_p1_ok <= ok1;
        s_p2_x <= x2;  s_p2_y <= y2;  s_p2_ok <= ok2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Pick a coordinate: full range, or a random offset near a base at one of three spreads.
    function automatic logic [31:0] pick_near(input logic [31:0] base, input int mode);
        case (mode)
            0: return $urandom;
            1: return base + 32'($urandom_range(0, 8)) - 32'd4;
            2: return base + 32'($urandom_range(0, 4096)) - 32'd2048;
            default: return base + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] bx, by;
        int mode;
        bit gap_ok;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_p0_x = '0; s_p0_y = '0; s_p0_ok = 1'b0;
        s_p1_x = '0; s_p1_y = '0; s_p1_ok = 1'b0;
        s_p2_x = '0; s_p2_y = '0; s_p2_ok = 1'b0;
        cycle_count  = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a missing point in each slot, all missing.
        drive_triple(0, 0, 0, 256, 0, 1, 256, 256, 1, 1);
        drive_triple(0, 0, 1, 256, 0, 0, 256, 256, 1, 1);
        drive_triple(0, 0, 1, 256, 0, 1, 256, 256, 0, 1);
        drive_triple(32'h7FFF_FFFF, 32'h8000_0000, 0, 5, 6, 0, 7, 8, 0, 1);
        // Collinear points and coincident points fall back to the default radius.
        drive_triple(0, 0, 1, 256, 256, 1, 512, 512, 1, 1);
        drive_triple(100, 100, 1, 100, 100, 1, 900, -300, 1, 1);
        drive_triple(7, 7, 1, 7, 7, 1, 7, 7, 1, 1);
        drive_triple(0, 0, 1, 9, 9, 1, 9, 9, 1, 1);
        // Zero dot product with a nonzero cross product.
        drive_triple(0, 0, 1, 5, 1, 1, 0, 1, 1, 1);
        // Tiny triangle: the quotient overflows and clamps.
        drive_triple(0, 0, 1, 1, 0, 1, 1, 1, 1, 1);
        // Ordinary unit-scale bends.
        drive_triple(0, 0, 1, 256, 0, 1, 512, 256, 1, 1);
        drive_triple(-2560, 0, 1, 0, 2560, 1, 2560, 0, 1, 1);
        // Coordinate extremes, both signs, wide spreads.
        drive_triple(32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
        drive_triple(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                     32'h8000_0000, 32'h8000_0000, 1, 1);
        drive_triple(32'h8000_0000, 0, 1, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, 1, 1);
        drive_triple(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h8000_0000, 1,
                     32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
        drive_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 1, 1, 32'hFFFF_FFFF, 1, 1);
        drive_triple(32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0001, 32'h8000_0000, 1,
                     32'h8000_0001, 32'h8000_0001, 1, 1);

        // Random: mostly valid triples clustered around a base point so the
        // geometry stays meaningful, with full-range and missing-point noise.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gap_ok = !(i >= 200 && i < 320);
            bx   = $urandom;
            by   = $urandom;
            mode = $urandom_range(0, 3);
            drive_triple(pick_near(bx, mode), pick_near(by, mode), $urandom_range(0, 99) >= 8,
                         pick_near(bx, mode), pick_near(by, mode), $urandom_range(0, 99) >= 8,
                         pick_near(bx, mode), pick_near(by, mode), $urandom_range(0, 99) >= 8,
                         gap_ok);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline settle.
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
